// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the pulse counter block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PCDT_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define PCDT_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

// ----- rtl/core/pcdt_pkg.sv -----
// ----------------------------------------------------------------------------
// pcdt_pkg
// Types, codes and constants of the dead-time pulse counter with storm guard.
// ----------------------------------------------------------------------------
package pcdt_pkg;

  // Timestamp arithmetic width (time kept modulo 2^min(TIME_BITS,32))
  localparam int TIME_BITS = 32;
  localparam int TIME_W    = (TIME_BITS < 32) ? TIME_BITS : 32;

  localparam int DEAD_W  = 20;
  localparam int CNT_W   = 32;
  localparam int COOL_W  = 8;
  localparam int FIELD_W = 32;
  localparam int CMP_W   = (TIME_W > DEAD_W) ? TIME_W : DEAD_W;

  // Register reset values
  localparam logic [DEAD_W-1:0] DEAD_TIME_RST       = 20'd500;
  localparam logic [CNT_W-1:0]  STORM_THRESHOLD_RST = 32'd10000;
  localparam logic [COOL_W-1:0] COOLDOWN_RST        = 8'd5;
  localparam logic              INPUT_ENABLE_RST    = 1'b1;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_PULSE   = 2'd0,
    OP_TICK    = 2'd1,
    OP_COLLECT = 2'd2,
    OP_LOAD    = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DEAD_TIME       = 2'd0,
    REG_STORM_THRESHOLD = 2'd1,
    REG_COOLDOWN        = 2'd2,
    REG_INPUT_ENABLE    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [DEAD_W-1:0] dead_time_us;
    logic [CNT_W-1:0]  storm_threshold;
    logic [COOL_W-1:0] cooldown_seconds;
    logic              input_enabled;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] last_accept_time;
    logic [CNT_W-1:0]  event_count;
    logic [CNT_W-1:0]  raw_edge_tally;
    logic [COOL_W-1:0] cooldown_left;
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [FIELD_W-1:0] timestamp_us;
    logic [CNT_W-1:0]   load_value;
    logic               restart_dead_time;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0]   count_value;
    logic               pulse_accepted;
    logic [FIELD_W-1:0] pulse_time;
    logic               storm_detected;
    logic               rearmed;
    logic               parked;
  } result_t;

endpackage

// ----- rtl/core/pcdt_update.sv -----
// ----------------------------------------------------------------------------
// pcdt_update
// Single-pass update: dead-time filter, storm guard and count handling for
// one request, giving the next state and the result.
// ----------------------------------------------------------------------------
module pcdt_update (
  input  pcdt_pkg::cfg_t    cfg,
  input  pcdt_pkg::state_t  state,
  input  pcdt_pkg::item_t   item,
  output pcdt_pkg::state_t  state_next,
  output pcdt_pkg::result_t result
);
  import pcdt_pkg::*;

  logic [TIME_W-1:0] ts;
  logic [TIME_W-1:0] elapsed;
  logic              dead_ok;
  logic              armed;
  logic [COOL_W-1:0] cool_dec;

  // Wrapping elapsed time since the last accepted pulse or dead-time restart
  assign ts       = item.timestamp_us[TIME_W-1:0];
  assign elapsed  = ts - state.last_accept_time;
  assign dead_ok  = CMP_W'(elapsed) >= CMP_W'(cfg.dead_time_us);
  assign armed    = cfg.input_enabled && (state.cooldown_left == '0);
  assign cool_dec = state.cooldown_left - COOL_W'(1);

  always_comb begin
    state_next            = state;
    result.count_value    = state.event_count;
    result.pulse_accepted = 1'b0;
    result.pulse_time     = '0;
    result.storm_detected = 1'b0;
    result.rearmed        = 1'b0;

    unique case (item.op)
      OP_PULSE: begin
        if (armed) begin
          state_next.raw_edge_tally = state.raw_edge_tally + CNT_W'(1);
          if (dead_ok) begin
            state_next.event_count      = state.event_count + CNT_W'(1);
            state_next.last_accept_time = ts;
            result.pulse_accepted       = 1'b1;
            result.pulse_time           = FIELD_W'(ts);
          end
        end
        result.count_value = state_next.event_count;
      end
      OP_TICK: begin
        // When input is enabled, tally is read and cleared; cooldown counts down or a storm loads the cooldown
        if (cfg.input_enabled) begin
          state_next.raw_edge_tally = '0;
          if (state.cooldown_left != '0) begin
            state_next.cooldown_left = cool_dec;
            result.rearmed           = (cool_dec == '0);
          end else if (state.raw_edge_tally > cfg.storm_threshold) begin
            state_next.cooldown_left = cfg.cooldown_seconds;
            result.storm_detected    = 1'b1;
          end
        end
      end
      OP_COLLECT: begin
        state_next.event_count = '0;
      end
      OP_LOAD: begin
        state_next.event_count = item.load_value;
        if (item.restart_dead_time) begin
          state_next.last_accept_time = ts;
        end
        result.count_value = item.load_value;
      end
      default: begin
        state_next = state;
      end
    endcase

    result.parked = (state_next.cooldown_left != '0);
  end

endmodule

// ----- rtl/core/pulse_counter_dead_time_storm_guard_core.sv -----
// ----------------------------------------------------------------------------
// pulse_counter_dead_time_storm_guard_core
// Dead-time pulse counter with raw-edge storm guard and cooldown.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_ready    op, timestamp_us, load_value,
//                                        restart_dead_time
//   out      out  out_valid / out_ready  count_value, pulse_accepted, pulse_time,
//                                        storm_detected, rearmed, parked
//   cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request per cycle sustained while results are taken; each result passes
// the request register, then the result register. The rate is set by the
// combinational state update in pcdt_update, which the next request sees at
// once.
// rst is synchronous: state cleared, registers to their defaults.
// A stalled result holds the result register; the request register keeps
// one request meanwhile, so in_ready drops only when both are full.
// cfg_ready is always high.
module pulse_counter_dead_time_storm_guard_core (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pcdt_pkg::op_t                  op,
  input  logic [pcdt_pkg::FIELD_W-1:0]   timestamp_us,
  input  logic [pcdt_pkg::CNT_W-1:0]     load_value,
  input  logic                           restart_dead_time,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pcdt_pkg::CNT_W-1:0]     count_value,
  output logic                           pulse_accepted,
  output logic [pcdt_pkg::FIELD_W-1:0]   pulse_time,
  output logic                           storm_detected,
  output logic                           rearmed,
  output logic                           parked,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  pcdt_pkg::reg_idx_t             cfg_index,
  input  logic [pcdt_pkg::CNT_W-1:0]     cfg_data
);
  import pcdt_pkg::*;

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  item_t   req;
  logic    req_valid;
  result_t res;
  result_t res_next;
  logic    advance;

  // Pipeline control
  assign advance   = req_valid && (!out_valid || out_ready);
  assign in_ready  = !req_valid || advance;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dead_time_us     <= DEAD_TIME_RST;
      cfg.storm_threshold  <= STORM_THRESHOLD_RST;
      cfg.cooldown_seconds <= COOLDOWN_RST;
      cfg.input_enabled    <= INPUT_ENABLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEAD_TIME:       cfg.dead_time_us     <= cfg_data[DEAD_W-1:0];
        REG_STORM_THRESHOLD: cfg.storm_threshold  <= cfg_data;
        REG_COOLDOWN:        cfg.cooldown_seconds <= cfg_data[COOL_W-1:0];
        REG_INPUT_ENABLE:    cfg.input_enabled    <= cfg_data[0];
        default:             cfg                  <= cfg;
      endcase
    end
  end

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req.op                <= op;
      req.timestamp_us      <= timestamp_us;
      req.load_value        <= load_value;
      req.restart_dead_time <= restart_dead_time;
    end
  end

  // Update logic
  pcdt_update u_update (
    .cfg        (cfg),
    .state      (state),
    .item       (req),
    .state_next (state_next),
    .result     (res_next)
  );

  // Counter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign count_value    = res.count_value;
  assign pulse_accepted = res.pulse_accepted;
  assign pulse_time     = res.pulse_time;
  assign storm_detected = res.storm_detected;
  assign rearmed        = res.rearmed;
  assign parked         = res.parked;

endmodule

// ----- rtl/core/pcdt_checker.sv -----
// ----------------------------------------------------------------------------
// pcdt_checker
// Port-level assertions for the pulse counter core, bound to the core module.
// ----------------------------------------------------------------------------
module pcdt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pcdt_pkg::CNT_W-1:0]   count_value,
  input logic                         pulse_accepted,
  input logic [pcdt_pkg::FIELD_W-1:0] pulse_time,
  input logic                         storm_detected,
  input logic                         rearmed,
  input logic                         parked
);
  `include "assert_macros.svh"

  // A stalled result holds its value
  `PCDT_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(count_value), "result changed while stalled")

  // Pulse time is zero unless the pulse was accepted
  `PCDT_ASSERT_IMPL(a_ptime, clk, rst, out_valid && !pulse_accepted, pulse_time == '0, "pulse_time set without accepted pulse")

  // Tick flags and pulse flag are exclusive
  `PCDT_ASSERT_IMPL(a_excl, clk, rst, out_valid && (storm_detected || rearmed), !pulse_accepted, "tick flag with accepted pulse")

  // Re-arm ends the cooldown, storm cannot coincide with re-arm
  `PCDT_ASSERT_IMPL(a_rearm, clk, rst, out_valid && rearmed, !parked && !storm_detected, "rearmed while still parked")

endmodule

bind pulse_counter_dead_time_storm_guard_core pcdt_checker u_pcdt_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .count_value    (count_value),
  .pulse_accepted (pulse_accepted),
  .pulse_time     (pulse_time),
  .storm_detected (storm_detected),
  .rearmed        (rearmed),
  .parked         (parked)
);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dead-time pulse counter with storm guard.
// A tracker class mirrors the count, dead-time window, raw-edge tally and
// cooldown, predicts one result per request and checks each returned result
// in order. A directed run covers the wrap, filter edges, storm, cooldown
// and disabled cases; random phases then sweep several register settings
// under changing backpressure.
// ----------------------------------------------------------------------------
module tb_top;
  import pcdt_pkg::*;

  localparam int CLK_LIMIT = 400000;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  op_t                  op;
  logic [FIELD_W-1:0]   timestamp_us;
  logic [CNT_W-1:0]     load_value;
  logic                 restart_dead_time;
  logic                 out_valid;
  logic                 out_ready;
  logic [CNT_W-1:0]     count_value;
  logic                 pulse_accepted;
  logic [FIELD_W-1:0]   pulse_time;
  logic                 storm_detected;
  logic                 rearmed;
  logic                 parked;
  logic                 cfg_valid;
  logic                 cfg_ready;
  reg_idx_t             cfg_index;
  logic [CNT_W-1:0]     cfg_data;

  // Tracks counter state and the results still owed by the block
  class count_tracker;
    logic [DEAD_W-1:0] dead_us;
    logic [CNT_W-1:0]  storm_limit;
    logic [COOL_W-1:0] cool_secs;
    logic              enabled;
    logic [TIME_W-1:0] last_pulse_us;
    logic [CNT_W-1:0]  pulse_count;
    logic [CNT_W-1:0]  edge_tally;
    logic [COOL_W-1:0] cool_left;
    result_t           owed_results[$];
    int                errors;

    function new();
      dead_us       = DEAD_TIME_RST;
      storm_limit   = STORM_THRESHOLD_RST;
      cool_secs     = COOLDOWN_RST;
      enabled       = INPUT_ENABLE_RST;
      last_pulse_us = '0;
      pulse_count   = '0;
      edge_tally    = '0;
      cool_left     = '0;
      errors        = 0;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function void record_config(reg_idx_t idx, logic [31:0] data);
      case (idx)
        REG_DEAD_TIME:       dead_us     = data[DEAD_W-1:0];
        REG_STORM_THRESHOLD: storm_limit = data;
        REG_COOLDOWN:        cool_secs   = data[COOL_W-1:0];
        REG_INPUT_ENABLE:    enabled     = data[0];
        default: ;
      endcase
    endfunction

    // Apply one accepted request and queue the result it must produce
    function void record_request(item_t it);
      result_t           res;
      logic [TIME_W-1:0] ts;
      logic [TIME_W-1:0] elapsed;
      logic [CNT_W-1:0]  seen;
      ts  = it.timestamp_us[TIME_W-1:0];
      res = '0;
      case (it.op)
        OP_PULSE: begin
          if (enabled && cool_left == '0) begin
            edge_tally = edge_tally + CNT_W'(1);
            elapsed    = ts - last_pulse_us;
            if (CMP_W'(elapsed) >= CMP_W'(dead_us)) begin
              pulse_count        = pulse_count + CNT_W'(1);
              last_pulse_us      = ts;
              res.pulse_accepted = 1'b1;
              res.pulse_time     = FIELD_W'(ts);
            end
          end
          res.count_value = pulse_count;
        end
        OP_TICK: begin
          if (enabled) begin
            seen       = edge_tally;
            edge_tally = '0;
            if (cool_left != '0) begin
              cool_left = cool_left - COOL_W'(1);
              if (cool_left == '0) res.rearmed = 1'b1;
            end else if (seen > storm_limit) begin
              cool_left          = cool_secs;
              res.storm_detected = 1'b1;
            end
          end
          res.count_value = pulse_count;
        end
        OP_COLLECT: begin
          res.count_value = pulse_count;
          pulse_count     = '0;
        end
        default: begin
          pulse_count = it.load_value;
          if (it.restart_dead_time) last_pulse_us = ts;
          res.count_value = pulse_count;
        end
      endcase
      res.parked = (cool_left != '0);
      owed_results.push_back(res);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    // Compare a returned result with the oldest one owed
    function void check_result(result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual count %h",
                 $time, got.count_value);
        return;
      end
      want = owed_results.pop_front();
      check_field("count_value", want.count_value, got.count_value);
      check_field("pulse_accepted", 32'(want.pulse_accepted), 32'(got.pulse_accepted));
      check_field("pulse_time", want.pulse_time, got.pulse_time);
      check_field("storm_detected", 32'(want.storm_detected), 32'(got.storm_detected));
      check_field("rearmed", 32'(want.rearmed), 32'(got.rearmed));
      check_field("parked", 32'(want.parked), 32'(got.parked));
    endfunction
  endclass

  count_tracker sb;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           requests_taken;
  int           next_hold_at = 150;
  int           hold_left = 0;
  int           cycle_count = 0;
  result_t      seen_result;

  pulse_counter_dead_time_storm_guard_core uut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .op                (op),
    .timestamp_us      (timestamp_us),
    .load_value        (load_value),
    .restart_dead_time (restart_dead_time),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .count_value       (count_value),
    .pulse_accepted    (pulse_accepted),
    .pulse_time        (pulse_time),
    .storm_detected    (storm_detected),
    .rearmed           (rearmed),
    .parked            (parked),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CLK_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random stalls plus long hold-offs that back up the input
  always @(negedge clk) begin
    if (requests_taken >= next_hold_at) begin
      hold_left    = 80;
      next_hold_at = next_hold_at + 550;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_result.count_value    = count_value;
      seen_result.pulse_accepted = pulse_accepted;
      seen_result.pulse_time     = pulse_time;
      seen_result.storm_detected = storm_detected;
      seen_result.rearmed        = rearmed;
      seen_result.parked         = parked;
      sb.check_result(seen_result);
    end
  end

  function automatic item_t mk(op_t o, logic [31:0] ts, logic [31:0] lv, logic rs);
    item_t it;
    it.op                = o;
    it.timestamp_us      = ts;
    it.load_value        = lv;
    it.restart_dead_time = rs;
    return it;
  endfunction

  // Offer one request; returns just after the falling edge that follows acceptance
  task automatic send_request(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    op                <= it.op;
    timestamp_us      <= it.timestamp_us;
    load_value        <= it.load_value;
    restart_dead_time <= it.restart_dead_time;
    do @(posedge clk); while (!in_ready);
    sb.record_request(it);
    requests_taken++;
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.record_config(idx, data);
    @(negedge clk);
  endtask

  task automatic configure(input logic [31:0] dead, input logic [31:0] thr,
                           input logic [31:0] cool, input logic [31:0] en);
    write_reg(REG_DEAD_TIME, dead);
    write_reg(REG_STORM_THRESHOLD, thr);
    write_reg(REG_COOLDOWN, cool);
    write_reg(REG_INPUT_ENABLE, en);
    cfg_valid <= 1'b0;
  endtask

  // Drain all owed results, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    logic [31:0] now_us;
    logic [31:0] dead;
    logic [31:0] thr;
    logic [31:0] cool;
    logic [31:0] en;
    logic [31:0] ts;
    logic [31:0] lv;
    int          dead_eff;
    int          target;
    int          sent;
    int          pick;
    item_t       it;

    sb                = new();
    rst               = 1'b1;
    in_valid          = 1'b0;
    op                = OP_PULSE;
    timestamp_us      = '0;
    load_value        = '0;
    restart_dead_time = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = REG_DEAD_TIME;
    cfg_data          = '0;
    send_idle_pct     = 11;
    recv_idle_pct     = 52;
    requests_taken    = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Dead-time filter edges at reset settings, count and timestamp wrap
    send_request(mk(OP_PULSE, 32'd0, 32'd0, 1'b0));
    send_request(mk(OP_PULSE, 32'd500, 32'hFFFF_FFFF, 1'b1));
    send_request(mk(OP_PULSE, 32'd999, 32'd0, 1'b0));
    send_request(mk(OP_PULSE, 32'd1000, 32'd0, 1'b0));
    send_request(mk(OP_COLLECT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    send_request(mk(OP_LOAD, 32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b1));
    send_request(mk(OP_PULSE, 32'h0000_00F3, 32'd0, 1'b0));
    send_request(mk(OP_PULSE, 32'h0000_00F4, 32'd0, 1'b0));
    send_request(mk(OP_TICK, 32'd0, 32'd0, 1'b0));
    send_request(mk(OP_LOAD, 32'hFFFF_FFFF, 32'd0, 1'b0));
    send_request(mk(OP_PULSE, 32'hFFFF_FFFF, 32'd0, 1'b0));
    settle();

    // Storm with zero cooldown: reported, nothing parked
    configure(32'hFFF0_0000, 32'd0, 32'h0000_0100, 32'd1);
    send_request(mk(OP_PULSE, 32'h1234_5678, 32'd0, 1'b0));
    send_request(mk(OP_TICK, 32'd0, 32'd0, 1'b0));
    send_request(mk(OP_PULSE, 32'h1234_5678, 32'd0, 1'b0));
    settle();

    // Park, ignored pulses, cooldown tick without compare, re-arm
    configure(32'd0, 32'd0, 32'd2, 32'd1);
    send_request(mk(OP_TICK, 32'd0, 32'd0, 1'b0));
    send_request(mk(OP_PULSE, 32'h0000_1000, 32'd0, 1'b0));
    send_request(mk(OP_TICK, 32'd0, 32'd0, 1'b0));
    send_request(mk(OP_PULSE, 32'h0000_2000, 32'd0, 1'b0));
    send_request(mk(OP_TICK, 32'd0, 32'd0, 1'b0));
    send_request(mk(OP_PULSE, 32'h0000_3000, 32'd0, 1'b0));
    settle();

    // Input disabled: pulses and ticks ignored, collect and load still work
    configure(32'd0, 32'd0, 32'd2, 32'hFFFF_FFFE);
    send_request(mk(OP_PULSE, 32'h0000_4000, 32'd0, 1'b0));
    send_request(mk(OP_TICK, 32'd0, 32'd0, 1'b0));
    send_request(mk(OP_COLLECT, 32'd0, 32'd0, 1'b0));
    send_request(mk(OP_LOAD, 32'h0000_5000, 32'd7, 1'b1));
    settle();

    // Random phases, each with its own register setting
    for (int phase = 0; phase < 7; phase++) begin
      if (phase <= 1) begin
        send_idle_pct = 11;
        recv_idle_pct = 52;
      end else if (phase <= 3) begin
        send_idle_pct = 52;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      now_us = $urandom;
      target = 150;
      en     = 32'd1;
      case (phase)
        0: begin
          dead = $urandom_range(0, 300);
          thr  = $urandom_range(0, 6);
          cool = $urandom_range(1, 4);
        end
        1: begin
          dead   = 32'd0;
          thr    = 32'd0;
          cool   = 32'd1;
          now_us = 32'hFFFF_F000;
        end
        2: begin
          dead = 32'h000F_FFFF;
          thr  = 32'hFFFF_FFFF;
          cool = 32'd255;
        end
        3: begin
          dead = $urandom;
          thr  = $urandom_range(0, 6);
          cool = 32'd0;
        end
        4: begin
          dead = $urandom_range(0, 1000);
          thr  = $urandom_range(2, 8);
          cool = $urandom_range(1, 6);
        end
        5: begin
          dead = $urandom_range(0, 50);
          thr  = $urandom_range(0, 6);
          cool = $urandom_range(1, 3);
        end
        default: begin
          dead   = $urandom_range(0, 100);
          thr    = $urandom_range(0, 6);
          cool   = $urandom_range(1, 3);
          en     = 32'd0;
          target = 30;
        end
      endcase
      configure(dead, thr, cool, en);
      dead_eff = int'(dead[DEAD_W-1:0]);
      sent     = 0;

      while (sent < target) begin
        pick = $urandom_range(99);
        ts   = $urandom;
        lv   = $urandom;
        if (pick < 68) begin
          // Mostly a steady stream of edges around the dead time, a few jumps
          if ($urandom_range(19) == 0) begin
            now_us = $urandom;
          end else begin
            now_us = now_us + $urandom_range(0, 2 * dead_eff + 4);
          end
          it = mk(OP_PULSE, now_us, lv, 1'($urandom_range(0, 1)));
        end else if (pick < 80) begin
          it = mk(OP_TICK, ts, lv, 1'($urandom_range(0, 1)));
        end else if (pick < 88) begin
          it = mk(OP_COLLECT, ts, lv, 1'($urandom_range(0, 1)));
        end else begin
          if ($urandom_range(3) == 0) lv = 32'hFFFF_FFFF - $urandom_range(0, 3);
          else if ($urandom_range(1) == 0) lv = $urandom_range(0, 20);
          if ($urandom_range(1) == 0) begin
            it = mk(OP_LOAD, now_us - $urandom_range(0, dead_eff), lv, 1'b1);
          end else begin
            it = mk(OP_LOAD, ts, lv, 1'b0);
          end
        end
        send_request(it);
        sent++;
      end
      settle();
    end

    // Final drain
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
